// ===== rtl/core/avc_config_record_extractor_core_defines.svh =====
// shared assertion macros for the record extractor
`ifndef AVC_CONFIG_RECORD_EXTRACTOR_CORE_DEFINES_SVH
`define AVC_CONFIG_RECORD_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AVC_CRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define AVC_CRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/avc_cre_pkg.sv =====
package avc_cre_pkg;

  localparam int unsigned AVC_CRE_HEADER_BYTES = 5;
  localparam int unsigned AVC_CRE_FIFO_DEPTH   = 4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DRAIN
  } avc_cre_phase_t;

  // one result beat
  typedef struct packed {
    logic        overrun;
    logic [15:0] copied_count;
    logic        done_res;
    logic        run_end;
    logic [7:0]  out_byte;
    logic        byte_valid;
  } avc_cre_res_t;

  // beats produced by one accepted byte, r0 goes out first
  typedef struct packed {
    logic [1:0]   cnt;
    avc_cre_res_t r1;
    avc_cre_res_t r0;
  } avc_cre_push_t;

endpackage

// ===== rtl/core/avc_cre_parse.sv =====
`include "avc_config_record_extractor_core_defines.svh"

module avc_cre_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   final_byte,
  input  logic [15:0]            total_length,
  output avc_cre_pkg::avc_cre_push_t push
);
  import avc_cre_pkg::*;

  avc_cre_phase_t phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        run_idx_r, run_idx_nxt;
  logic [4:0]  entries_r, entries_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] payload_r, payload_nxt;
  logic [15:0] copied_r, copied_nxt;
  logic        overrun_r, overrun_nxt;

  logic [15:0] len;
  logic [15:0] start;
  logic [17:0] reach;
  logic [4:0]  entries_dec;
  logic [15:0] payload_dec;
  logic [1:0]  n_copy;
  logic [7:0]  b0, b1;
  avc_cre_phase_t run_end_phase;
  logic        run_end_idx;

  always_comb begin
    len         = {len_hi_r, data_byte};
    start       = (pos_r == '0) ? '0 : pos_r - 16'd1;
    reach       = {2'b00, start} + {2'b00, len} + 18'd2;
    entries_dec = entries_r - 5'd1;
    payload_dec = payload_r - 16'd1;
    // what ending the current run leads to
    if (run_idx_r == 1'b0) begin
      run_end_phase = PH_COUNT;
      run_end_idx   = 1'b1;
    end else begin
      run_end_phase = PH_DRAIN;
      run_end_idx   = run_idx_r;
    end

    phase_nxt   = phase_r;
    run_idx_nxt = run_idx_r;
    entries_nxt = entries_r;
    len_hi_nxt  = len_hi_r;
    payload_nxt = payload_r;
    copied_nxt  = copied_r;
    overrun_nxt = overrun_r;
    n_copy      = 2'd0;
    b0          = '0;
    b1          = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r >= 16'(AVC_CRE_HEADER_BYTES - 1)) phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        entries_nxt = data_byte[4:0];
        if (data_byte[4:0] == '0) begin
          phase_nxt   = run_end_phase;
          run_idx_nxt = run_end_idx;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = data_byte;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (reach > {2'b00, total_length}) begin
          overrun_nxt = 1'b1;
          phase_nxt   = PH_DRAIN;
        end else begin
          n_copy      = 2'd2;
          b0          = len_hi_r;
          b1          = data_byte;
          copied_nxt  = (copied_r >= 16'hfffe) ? 16'hffff : copied_r + 16'd2;
          payload_nxt = len;
          if (len == '0) begin
            entries_nxt = entries_dec;
            if (entries_dec == '0) begin
              phase_nxt   = run_end_phase;
              run_idx_nxt = run_end_idx;
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        n_copy      = 2'd1;
        b0          = data_byte;
        copied_nxt  = (copied_r == 16'hffff) ? copied_r : copied_r + 16'd1;
        payload_nxt = payload_dec;
        if (payload_dec == '0) begin
          entries_nxt = entries_dec;
          if (entries_dec == '0) begin
            phase_nxt   = run_end_phase;
            run_idx_nxt = run_end_idx;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
      end
      default: phase_nxt = PH_DRAIN;
    endcase

    pos_nxt = (pos_r == 16'hffff) ? pos_r : pos_r + 16'd1;

    // result beats
    push.r0.byte_valid   = (n_copy != 2'd0);
    push.r0.out_byte     = b0;
    push.r0.copied_count = copied_nxt;
    push.r0.overrun      = overrun_nxt;
    push.r0.run_end      = (n_copy != 2'd2);
    push.r0.done_res     = final_byte && (n_copy != 2'd2);
    push.r1.byte_valid   = 1'b1;
    push.r1.out_byte     = b1;
    push.r1.copied_count = copied_nxt;
    push.r1.overrun      = overrun_nxt;
    push.r1.run_end      = 1'b1;
    push.r1.done_res     = final_byte;
    if (!accept) push.cnt = 2'd0;
    else if (n_copy == 2'd0) push.cnt = final_byte ? 2'd1 : 2'd0;
    else push.cnt = n_copy;

    // end of record: parse state back to its reset values
    if (final_byte) begin
      phase_nxt   = PH_HEADER;
      pos_nxt     = '0;
      run_idx_nxt = 1'b0;
      entries_nxt = '0;
      payload_nxt = '0;
      copied_nxt  = '0;
      overrun_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      run_idx_r <= 1'b0;
      entries_r <= '0;
      payload_r <= '0;
      copied_r  <= '0;
      overrun_r <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      run_idx_r <= run_idx_nxt;
      entries_r <= entries_nxt;
      payload_r <= payload_nxt;
      copied_r  <= copied_nxt;
      overrun_r <= overrun_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) len_hi_r <= len_hi_nxt;
  end

  `AVC_CRE_ASSERT_NOW(a_two_beats_len_lo, push.cnt == 2'd2, phase_r == PH_LEN_LO, "two beats outside length phase")
  `AVC_CRE_ASSERT_NEXT(a_final_clears, accept && final_byte, phase_r == PH_HEADER && copied_r == '0, "record state not cleared")
  `AVC_CRE_ASSERT_NEXT(a_overrun_sticky, overrun_r && !(accept && final_byte), overrun_r, "overrun flag dropped")

endmodule

// ===== rtl/core/avc_cre_ofifo.sv =====
`include "avc_config_record_extractor_core_defines.svh"

module avc_cre_ofifo #(
  parameter int unsigned DEPTH = avc_cre_pkg::AVC_CRE_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  avc_cre_pkg::avc_cre_push_t    push,
  output logic                          room,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output avc_cre_pkg::avc_cre_res_t     pop_data
);
  import avc_cre_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  avc_cre_res_t  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, wptr_p1, rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  always_comb begin
    pop       = pop_valid && pop_ready;
    wptr_p1   = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    wptr_nxt  = wptr_r;
    if (push.cnt == 2'd1) wptr_nxt = wptr_p1;
    else if (push.cnt == 2'd2) wptr_nxt = (wptr_p1 == PW'(DEPTH - 1)) ? '0 : wptr_p1 + PW'(1);
    rptr_nxt  = rptr_r;
    if (pop) rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rptr_r];
  // room for the worst case of two beats from one byte
  assign room      = ({1'b0, count_r} + (CW + 1)'(2)) <= (CW + 1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wptr_p1] <= push.r1;
  end

  `AVC_CRE_ASSERT_NOW(a_no_overflow, push.cnt != 2'd0, ({1'b0, count_r} + (CW + 1)'(push.cnt)) <= (CW + 1)'(DEPTH), "queue overflow")
  `AVC_CRE_ASSERT_NEXT(a_pop_only, pop && push.cnt == 2'd0, count_r == $past(count_r) - CW'(1), "count not reduced by pop")

endmodule

// ===== rtl/core/avc_config_record_extractor_core.sv =====
// avc decoder configuration record extractor: bytes of the record arrive one per beat
// on the in_ stream (tlast marks the final byte). the five header bytes are skipped,
// then the sps run and the pps run are parsed: a count byte (low five bits), then per
// entry a big-endian 16-bit length and its data bytes. length and data bytes are
// passed out unchanged, one byte per out_ beat. an entry reaching past total_length
// (cfg register) stops all copying and raises overrun until the record ends. bytes
// after the second run are dropped. the final byte always yields a beat with done set
// and the number of bytes copied; the parser then returns to its reset state.
// rate: one input byte per cycle while in_tready is high; a byte yields zero, one or two
// output beats, the two-beat case being the low length byte, which releases both length
// bytes at once after the overrun check. results leave through a FIFO_DEPTH-entry queue
// at one beat per cycle while out_tready is high; in_tready drops while the queue has room
// for fewer than two beats. an accepted byte's beats are written to the queue on accept.
module avc_config_record_extractor_core #(
  parameter int unsigned FIFO_DEPTH = avc_cre_pkg::AVC_CRE_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: total record length
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // final_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte [7:0], copied_count [23:8], overrun [24], zero
  output logic [1:0]  out_tuser,  // byte_valid [0], done_res [1]
  output logic        out_tlast   // run_end
);
  import avc_cre_pkg::*;

  logic [15:0]   total_length_r;
  logic          in_accept;
  avc_cre_push_t push;
  avc_cre_res_t  res;

  // config register, the user must write it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= '0;
    end else if (cfg_wr_en) begin
      total_length_r <= cfg_wr_data;
    end
  end

  assign in_accept = in_tvalid && in_tready;

  // per-byte parse state machine, results computed in the accept cycle
  avc_cre_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .data_byte    (in_tdata),
    .final_byte   (in_tlast),
    .total_length (total_length_r),
    .push         (push)
  );

  // result queue decouples the one-or-two beat bursts from the consumer
  avc_cre_ofifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (res)
  );

  // beat packing
  assign out_tdata = {7'b0, res.overrun, res.copied_count, res.out_byte};
  assign out_tuser = {res.done_res, res.byte_valid};
  assign out_tlast = res.run_end;

endmodule

// ===== tb/avc_config_record_extractor_checker.sv =====
module avc_config_record_extractor_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          beats_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import avc_cre_pkg::*;

  // predicted parser state
  logic [15:0]    record_len;
  avc_cre_phase_t parse_phase;
  logic [15:0]    byte_pos;
  logic           pps_run;
  logic [4:0]     entries_left;
  logic [7:0]     len_high;
  logic [15:0]    data_left;
  logic [15:0]    copied_bytes;
  logic           overrun_hit;

  avc_cre_res_t   beats_due[$];

  task automatic clear_parser();
    parse_phase  = PH_HEADER;
    byte_pos     = '0;
    pps_run      = 1'b0;
    entries_left = '0;
    len_high     = '0;
    data_left    = '0;
    copied_bytes = '0;
    overrun_hit  = 1'b0;
  endtask

  task automatic close_run();
    if (!pps_run) begin
      pps_run     = 1'b1;
      parse_phase = PH_COUNT;
    end else begin
      parse_phase = PH_DRAIN;
    end
  endtask

  task automatic close_entry();
    entries_left = entries_left - 5'd1;
    if (entries_left == 0) close_run();
    else parse_phase = PH_LEN_HI;
  endtask

  task automatic count_copied();
    if (copied_bytes != 16'hffff) copied_bytes = copied_bytes + 16'd1;
  endtask

  task automatic parse_record_byte(input logic [7:0] b, input logic fin);
    logic [7:0]   emit [2];
    int           n;
    int unsigned  start;
    logic [15:0]  entry_len;
    avc_cre_res_t r;
    n = 0;
    case (parse_phase)
      PH_HEADER: begin
        if (int'(byte_pos) + 1 >= AVC_CRE_HEADER_BYTES) parse_phase = PH_COUNT;
      end
      PH_COUNT: begin
        entries_left = b[4:0];
        if (entries_left == 0) close_run();
        else parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_high    = b;
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        entry_len = {len_high, b};
        start = (byte_pos == 0) ? 0 : int'(byte_pos) - 1;
        if (start + entry_len + 2 > record_len) begin
          overrun_hit = 1'b1;
          parse_phase = PH_DRAIN;
        end else begin
          emit[0] = len_high;
          emit[1] = b;
          n = 2;
          count_copied();
          count_copied();
          data_left = entry_len;
          if (entry_len == 0) close_entry();
          else parse_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit[0] = b;
        n = 1;
        count_copied();
        data_left = data_left - 16'd1;
        if (data_left == 0) close_entry();
      end
      default: parse_phase = PH_DRAIN;
    endcase
    if (byte_pos != 16'hffff) byte_pos = byte_pos + 16'd1;

    for (int k = 0; k < n; k++) begin
      r = '0;
      r.byte_valid   = 1'b1;
      r.out_byte     = emit[k];
      r.copied_count = copied_bytes;
      r.overrun      = overrun_hit;
      r.run_end      = (k == n - 1);
      r.done_res     = fin && (k == n - 1);
      beats_due.push_back(r);
    end
    // final byte that copied nothing still reports the count
    if (fin && n == 0) begin
      r = '0;
      r.copied_count = copied_bytes;
      r.overrun      = overrun_hit;
      r.run_end      = 1'b1;
      r.done_res     = 1'b1;
      beats_due.push_back(r);
    end
    if (fin) clear_parser();
  endtask

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    avc_cre_res_t want;
    if (!rst_n) begin
      record_len = '0;
      clear_parser();
      beats_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual tdata 0x%0h tuser %b tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = beats_due.pop_front();
          check_field("byte_valid", want.byte_valid, out_tuser[0]);
          check_field("out_byte", want.out_byte, out_tdata[7:0]);
          check_field("run_end", want.run_end, out_tlast);
          check_field("done_res", want.done_res, out_tuser[1]);
          check_field("copied_count", want.copied_count, out_tdata[23:8]);
          check_field("overrun", want.overrun, out_tdata[24]);
          check_field("tdata padding", 0, out_tdata[31:25]);
        end
      end
      if (cfg_wr_en) record_len = cfg_wr_data;
      if (in_tvalid && in_tready) parse_record_byte(in_tdata, in_tlast);
    end
    beats_pending <= beats_due.size();
  end

endmodule

// ===== tb/avc_config_record_extractor_core_tb.sv =====
module avc_config_record_extractor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // generous cap on the whole run, allows for every stall
  localparam int unsigned CYCLE_LIMIT   = 40000;
  // receiver hold-off, long enough to fill the result queue
  localparam int unsigned HOLD_CYCLES   = 64;
  // least number of input beats per random phase
  localparam int unsigned PHASE_ITEMS   = 100;
  // pause after the last result, covers bytes that give no beat
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          beats_pending;
  int unsigned cycle_cnt   = 0;

  // when set both sides run back to back
  bit          no_idle     = 1'b0;
  // asks the receiver for one long hold-off
  bit          stall_long  = 1'b0;

  // bytes of the record about to be sent
  logic [7:0]  rec_q[$];

  initial begin
    forever #1 clk = ~clk;
  end

  avc_config_record_extractor_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  avc_config_record_extractor_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .beats_pending (beats_pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls per beat, plus one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_long && !held) begin
        // sender keeps pushing, so the queue fills and in_tready drops
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // one input beat with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  // last byte of the queue carries tlast
  task automatic send_record(input bit fast);
    no_idle = fast || ($urandom_range(0, 3) == 0);
    foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
  endtask

  // wait for every predicted beat, then let trailing skipped bytes clear the pipe
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total_length(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly well-formed records with random content, some noise, some cut short
  task automatic build_record();
    int n;
    int len;
    int cut;
    rec_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // plain noise
      repeat ($urandom_range(1, 20)) rec_q.push_back(8'($urandom));
      return;
    end
    repeat (5) rec_q.push_back(8'($urandom));
    for (int run = 0; run < 2; run++) begin
      // the count may claim more entries than are actually laid out
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      rec_q.push_back({3'($urandom), 5'(n)});
      for (int ent = 0; ent < n && ent < 4; ent++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
        rec_q.push_back(8'(len >> 8));
        rec_q.push_back(8'(len));
        repeat ((len < 12) ? len : $urandom_range(0, 12)) rec_q.push_back(8'($urandom));
      end
    end
    // trailing bytes after the pps run get dropped
    repeat ($urandom_range(0, 3)) rec_q.push_back(8'($urandom));
    // final byte mid-record
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, rec_q.size());
      while (rec_q.size() > cut) void'(rec_q.pop_back());
    end
  endtask

  initial begin
    int unsigned total_len_set [5];
    int unsigned sent;
    total_len_set = '{20, 40, 64, 150, 32'($urandom_range(0, 65535))};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero record length: the first entry overruns, final byte lands in drain
    write_total_length(16'd0);
    rec_q = '{8'h00, 8'hff, 8'haa, 8'h55, 8'hff, 8'he1, 8'h00, 8'h00, 8'hff};
    send_record(1'b0);
    settle();

    // widest length: empty sps run, pps with a zero-length and a two-byte entry,
    // then a dropped trailing byte carrying tlast
    write_total_length(16'hffff);
    rec_q = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'h00, 8'he2,
              8'h00, 8'h00, 8'h00, 8'h02, 8'hff, 8'h00, 8'haa};
    send_record(1'b0);
    // one-byte record, final inside the header
    rec_q = '{8'h5a};
    send_record(1'b0);
    settle();

    // random phases, each at its own record length
    for (int p = 0; p < 5; p++) begin
      write_total_length(16'(total_len_set[p]));
      stall_long = (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_record();
        sent += rec_q.size();
        send_record(1'b0);
      end
      settle();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
